// ===== hdl/bdl_pkg.sv =====
// ---------------------------------------------------------------------------
// Bounded double-ended list package
// Shared sizes, action and status codes, cell control codes and types.
// ---------------------------------------------------------------------------
package bdl_pkg;

	localparam int CAPACITY  = 256;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int LEN_W     = $clog2(CAPACITY + 1);
	localparam int WORD_W    = 24;
	localparam int GRP_N     = 16;
	localparam int NGRP      = CAPACITY / GRP_N;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 40;

	localparam logic [2:0] ACT_INS_HEAD = 3'd0;
	localparam logic [2:0] ACT_INS_TAIL = 3'd1;
	localparam logic [2:0] ACT_REM_HEAD = 3'd2;
	localparam logic [2:0] ACT_REM_TAIL = 3'd3;
	localparam logic [2:0] ACT_RD_TAIL  = 3'd4;
	localparam logic [2:0] ACT_RD_IDX   = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [1:0] CELL_HOLD = 2'd0;
	localparam logic [1:0] CELL_SHR  = 2'd1;
	localparam logic [1:0] CELL_SHL  = 2'd2;
	localparam logic [1:0] CELL_LOAD = 2'd3;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] target;
		word_t            wdata;
	} cell_ctl_t;

endpackage

// ===== hdl/bdl_cell.sv =====
// ---------------------------------------------------------------------------
// List cell
// Holds one entry; shifts toward head or tail, loads when addressed, and
// drives its entry onto the read tree when its position is selected.
// ---------------------------------------------------------------------------
module bdl_cell import bdl_pkg::*; (
	input  logic             clk,
	input  logic [IDX_W-1:0] idx,
	input  cell_ctl_t        ctl,
	input  word_t            prev_word,
	input  word_t            next_word,
	output word_t            word,
	output word_t            rd_word
);

	word_t word_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_SHR: begin
				word_q <= prev_word;
			end
			CELL_SHL: begin
				word_q <= next_word;
			end
			CELL_LOAD: begin
				if (idx == ctl.target) begin
					word_q <= ctl.wdata;
				end
			end
			default: begin
			end
		endcase
	end

	assign word    = word_q;
	assign rd_word = (idx == ctl.target) ? word_q : '0;

endmodule

// ===== hdl/bounded_double_ended_list_core.sv =====
// ---------------------------------------------------------------------------
// Bounded double-ended list core
// Ordered list of up to CAPACITY (x, y, symbol) entries kept in a chain of
// cells, with head and tail insert/remove and indexed read.
// ---------------------------------------------------------------------------
// Usage:
// Each transfer on the slave side carries one action in s_tuser and the
// entry and slot in s_tdata. Each action gives exactly one result transfer
// on the master side: the entry read (zeros when nothing is read), the
// length after the action in m_tdata, and the status in m_tuser.
// The entries sit in a row of cells, head in cell zero. Inserting at the
// head shifts the whole row one cell toward the tail, removing the head
// shifts it back, a tail insert loads only the cell at the length.
// A read selects one cell; its entry reaches the output through a
// registered OR tree of two levels (groups of sixteen cells).
// An update passes from idle through the done state to the output register;
// a read also passes the read state, where the second tree level is
// registered. The block takes no new item until the last result is loaded;
// s_tready is high only between items.
// A finished result waits in the output register while the next item is
// taken; the block stalls before loading a new result over one that the
// receiver has not yet taken.
// Reset clears the length and the output valid; cell contents are not
// cleared, since only entries inside the length are ever read.
// ---------------------------------------------------------------------------
module bounded_double_ended_list_core import bdl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata fields from bit 0: pos_x[7:0], pos_y[15:8], glyph[23:16], slot[31:24]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser fields from bit 0: action[2:0]
	input  logic [2:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata fields from bit 0: out_x[7:0], out_y[15:8], out_glyph[23:16],
	// length[32:24], zero fill[39:33]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// m_tuser fields from bit 0: status[1:0]
	output logic [1:0]            m_tuser
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;
	localparam int PAD_W = OUT_DATA_W - LEN_W - WORD_W;

	logic [1:0]       state_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] res_len_q;
	logic [1:0]       res_status_q;
	logic             have_data_q;
	word_t            grp_s1 [NGRP];
	word_t            rd_s2;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0]            m_tuser_q;

	logic             accept;
	logic             out_free;
	logic [2:0]       act;
	word_t            wword;
	logic [IDX_W-1:0] slot;
	logic             full;
	logic             empty;
	logic [1:0]       op_raw;
	cell_ctl_t        ctl;
	logic [LEN_W-1:0] nxt_len;
	logic [1:0]       nxt_status;
	logic             nxt_read;
	word_t            cell_word [CAPACITY];
	word_t            cell_rd   [CAPACITY];
	word_t            grp_or    [NGRP];
	word_t            tree_or;
	word_t            res_data;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Entry word keeps x in the top byte, then y, then the symbol.
	assign act   = s_tuser;
	assign wword = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
	assign slot  = s_tdata[31:24];
	assign full  = (len_q == LEN_W'(CAPACITY));
	assign empty = (len_q == '0);

	// Decode the action against the current length. Refused actions and the
	// unused codes leave the cells and the length alone.
	always_comb begin
		op_raw     = CELL_HOLD;
		ctl.target = slot;
		ctl.wdata  = wword;
		nxt_len    = len_q;
		nxt_status = ST_OK;
		nxt_read   = 1'b0;
		case (act)
			ACT_INS_HEAD: begin
				if (full) begin
					nxt_status = ST_FULL;
				end else begin
					op_raw  = CELL_SHR;
					nxt_len = len_q + LEN_W'(1);
				end
			end
			ACT_INS_TAIL: begin
				if (full) begin
					nxt_status = ST_FULL;
				end else begin
					op_raw     = CELL_LOAD;
					ctl.target = len_q[IDX_W-1:0];
					nxt_len    = len_q + LEN_W'(1);
				end
			end
			ACT_REM_HEAD: begin
				if (empty) begin
					nxt_status = ST_EMPTY;
				end else begin
					op_raw  = CELL_SHL;
					nxt_len = len_q - LEN_W'(1);
				end
			end
			ACT_REM_TAIL: begin
				if (empty) begin
					nxt_status = ST_EMPTY;
				end else begin
					nxt_len = len_q - LEN_W'(1);
				end
			end
			ACT_RD_TAIL: begin
				if (empty) begin
					nxt_status = ST_EMPTY;
				end else begin
					ctl.target = IDX_W'(len_q - LEN_W'(1));
					nxt_read   = 1'b1;
				end
			end
			ACT_RD_IDX: begin
				if (LEN_W'(slot) >= len_q) begin
					nxt_status = ST_RANGE;
				end else begin
					nxt_read = 1'b1;
				end
			end
			default: begin
			end
		endcase
		ctl.op = accept ? op_raw : CELL_HOLD;
	end

	// The row of cells. Cell zero takes the new head entry on a right shift;
	// the last cell takes zeros on a left shift.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t prev_w;
		word_t next_w;
		if (i == 0) begin : g_first
			assign prev_w = wword;
		end else begin : g_mid
			assign prev_w = cell_word[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_inner
			assign next_w = cell_word[i+1];
		end
		bdl_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(i)),
			.ctl       (ctl),
			.prev_word (prev_w),
			.next_word (next_w),
			.word      (cell_word[i]),
			.rd_word   (cell_rd[i])
		);
	end

	// First tree level: one OR per group of cells, captured with the item.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < GRP_N; k++) begin
				grp_or[g] = grp_or[g] | cell_rd[g*GRP_N + k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int g = 0; g < NGRP; g++) begin
				grp_s1[g] <= grp_or[g];
			end
		end
	end

	// Second tree level across the groups.
	always_comb begin
		tree_or = '0;
		for (int g = 0; g < NGRP; g++) begin
			tree_or = tree_or | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rd_s2 <= tree_or;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_len_q    <= nxt_len;
			res_status_q <= nxt_status;
			have_data_q  <= nxt_read;
		end
	end

	assign res_data = have_data_q ? rd_s2 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			len_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// Loading a new result takes priority over clearing the old one.
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						len_q   <= nxt_len;
						state_q <= nxt_read ? S_READ : S_DONE;
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_tdata_q <= {{PAD_W{1'b0}}, res_len_q, res_data[7:0], res_data[15:8],
				res_data[23:16]};
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
